// ----- rtl/dege_pkg.sv -----
// Shared types and constants for the dispatch end guard sequencer.
// Used by dege_cell, dege_window and dispatch_end_guard_sequencer; no dependencies.
package dege_pkg;

  localparam int WINDOW_DEPTH_DEF = 64;

  localparam int ID_W   = 32;
  localparam int KIND_W = 2;
  localparam int CNT_W  = 48;
  localparam int CAUSE_W = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [KIND_W-1:0] KIND_BEGIN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd1;

  localparam logic [CAUSE_W-1:0] CAUSE_NONE  = 2'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_ENDED = 2'd1;
  localparam logic [CAUSE_W-1:0] CAUSE_LINK  = 2'd2;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctl_t;

endpackage

// ----- rtl/dege_cell.sv -----
// One window cell: a dispatch id, its live mark and a registered id compare.
// Depends on dege_pkg.
module dege_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dege_pkg::cell_ctl_t      ctl,
  input  logic [dege_pkg::ID_W-1:0] cmp_id,
  input  logic [dege_pkg::ID_W-1:0] prev_id,
  input  logic                     prev_live,
  output logic [dege_pkg::ID_W-1:0] id_o,
  output logic                     live_o,
  output logic                     hit_o
);

  logic [dege_pkg::ID_W-1:0] id_r;
  logic                      live_r;
  logic                      eq_r;

  always_ff @(posedge clk) begin
    eq_r <= (id_r == cmp_id);
    if (ctl.shift) begin
      id_r <= prev_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= 1'b0;
    end else if (ctl.shift) begin
      live_r <= prev_live;
    end else if (ctl.clear && eq_r) begin
      live_r <= 1'b0;
    end
  end

  assign id_o   = id_r;
  assign live_o = live_r;
  assign hit_o  = live_r & eq_r;

endmodule

// ----- rtl/dege_window.sv -----
// Window of ended dispatch ids as a chain of cells, newest entry in cell 0.
// Depends on dege_pkg and dege_cell.
module dege_window #(
  parameter int WINDOW_DEPTH = dege_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  dege_pkg::cell_ctl_t       ctl,
  input  logic [dege_pkg::ID_W-1:0] cmp_id,
  output logic                      any_hit
);

  logic [dege_pkg::ID_W-1:0] chain_id   [WINDOW_DEPTH+1];
  logic                      chain_live [WINDOW_DEPTH+1];
  logic [WINDOW_DEPTH-1:0]   hit;

  assign chain_id[0]   = cmp_id;
  assign chain_live[0] = 1'b1;

  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    dege_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .cmp_id    (cmp_id),
      .prev_id   (chain_id[i]),
      .prev_live (chain_live[i]),
      .id_o      (chain_id[i+1]),
      .live_o    (chain_live[i+1]),
      .hit_o     (hit[i])
    );
  end

  assign any_hit = |hit;

endmodule

// ----- rtl/dispatch_end_guard_sequencer.sv -----
// Dispatch end guard sequencer: stamps trace events with gapless sequence numbers.
// Depends on dege_pkg and dege_window.
//
// Each event passes through a match state, which compares its id against every
// window cell at once, and a decide state, which updates the cells and the
// counters; the next event is taken in the deciding cycle whenever the result
// register is empty or out_tready is high. The window is a chain of WINDOW_DEPTH
// cells; an end event that is sent pushes its id into the first cell and moves
// every entry one cell on, the oldest dropping out of the last cell. Sequence
// numbers start at one and stick at 2^48-1; both totals saturate there.
module dispatch_end_guard_sequencer #(
  parameter int WINDOW_DEPTH = dege_pkg::WINDOW_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,   // event_id[31:0], link_ready[32], zero pad
  input  logic [1:0]   in_tuser,   // kind[1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [151:0] out_tdata   // accepted[0], refuse_cause[2:1],
                                   // sequence_number[50:3], accepted_total[98:51],
                                   // rejected_total[146:99], zero pad
);

  typedef enum logic [1:0] {S_IDLE, S_MATCH, S_DECIDE} state_t;

  state_t                          state_r, state_nxt;
  logic [dege_pkg::KIND_W-1:0]     kind_r;
  logic [dege_pkg::ID_W-1:0]       id_r;
  logic                            ready_r;
  logic [dege_pkg::CNT_W-1:0]      next_seq_r, acc_cnt_r, rej_cnt_r;
  logic [dege_pkg::CNT_W-1:0]      next_seq_nxt, acc_cnt_nxt, rej_cnt_nxt;
  logic                            out_vld_r, out_vld_nxt;
  logic                            out_acc_r;
  logic [dege_pkg::CAUSE_W-1:0]    out_cause_r;
  logic [dege_pkg::CNT_W-1:0]      out_seq_r;

  logic                            any_hit;
  logic                            out_free, fire, take, in_xfer;
  logic                            is_begin, is_end;
  logic [dege_pkg::CAUSE_W-1:0]    cause;
  dege_pkg::cell_ctl_t             ctl;

  assign out_free  = !out_vld_r || out_tready;
  assign fire      = (state_r == S_DECIDE) && out_free;
  assign in_tready = (state_r == S_IDLE) || fire;
  assign in_xfer   = in_tvalid && in_tready;

  assign is_begin = (kind_r == dege_pkg::KIND_BEGIN);
  assign is_end   = (kind_r == dege_pkg::KIND_END);

  always_comb begin
    if (!is_begin && any_hit) begin
      cause = dege_pkg::CAUSE_ENDED;
    end else if (!ready_r) begin
      cause = dege_pkg::CAUSE_LINK;
    end else begin
      cause = dege_pkg::CAUSE_NONE;
    end
  end

  assign take      = fire && (cause == dege_pkg::CAUSE_NONE);
  assign ctl.clear = take && is_begin;
  assign ctl.shift = take && is_end;

  dege_window #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .cmp_id  (id_r),
    .any_hit (any_hit)
  );

  always_comb begin
    state_nxt    = state_r;
    next_seq_nxt = next_seq_r;
    acc_cnt_nxt  = acc_cnt_r;
    rej_cnt_nxt  = rej_cnt_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_MATCH;
        end
      end
      S_MATCH: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (fire) begin
          out_vld_nxt = 1'b1;
          state_nxt   = in_xfer ? S_MATCH : S_IDLE;
          if (take) begin
            if (next_seq_r != dege_pkg::CNT_MAX) begin
              next_seq_nxt = next_seq_r + 1'b1;
            end
            if (acc_cnt_r != dege_pkg::CNT_MAX) begin
              acc_cnt_nxt = acc_cnt_r + 1'b1;
            end
          end else if (rej_cnt_r != dege_pkg::CNT_MAX) begin
            rej_cnt_nxt = rej_cnt_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      next_seq_r <= {{(dege_pkg::CNT_W-1){1'b0}}, 1'b1};
      acc_cnt_r  <= '0;
      rej_cnt_r  <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      next_seq_r <= next_seq_nxt;
      acc_cnt_r  <= acc_cnt_nxt;
      rej_cnt_r  <= rej_cnt_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      kind_r  <= in_tuser;
      id_r    <= in_tdata[31:0];
      ready_r <= in_tdata[32];
    end
    if (fire) begin
      out_acc_r   <= (cause == dege_pkg::CAUSE_NONE);
      out_cause_r <= cause;
      out_seq_r   <= take ? next_seq_r : '0;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'd0, rej_cnt_r, acc_cnt_r, out_seq_r, out_cause_r, out_acc_r};

endmodule

// ----- tb/dege_stamp_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the dispatch end guard sequencer: watches both stream channels,
// keeps its own window of ended ids, and checks every stamped result in order.
// Depends on dege_pkg.
module dege_stamp_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [39:0]  in_tdata,   // event_id[31:0], link_ready[32], zero pad
  input  logic [1:0]   in_tuser,   // kind[1:0]
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [151:0] out_tdata,  // accepted[0], refuse_cause[2:1],
                                   // sequence_number[50:3], accepted_total[98:51],
                                   // rejected_total[146:99], zero pad
  output int           fail_count,
  output int           pending,
  output int           sent_count,
  output int           ended_count,
  output int           link_count,
  output int           evict_count
);

  localparam int CW = dege_pkg::CNT_W;

  typedef struct {
    logic                         accepted;
    logic [dege_pkg::CAUSE_W-1:0] cause;
    logic [CW-1:0]                seq;
    logic [CW-1:0]                sent_total;
    logic [CW-1:0]                refused_total;
  } stamp_t;

  stamp_t                    expected_stamps[$];
  logic [dege_pkg::ID_W-1:0] ended_ids[$];
  bit                        ended_live[$];
  logic [CW-1:0]             next_seq;
  logic [CW-1:0]             sent_total;
  logic [CW-1:0]             refused_total;

  function automatic bit id_live(logic [dege_pkg::ID_W-1:0] id);
    foreach (ended_ids[i])
      if (ended_live[i] && ended_ids[i] == id) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [CW-1:0] sat_inc(logic [CW-1:0] v);
    return (v == dege_pkg::CNT_MAX) ? v : v + 1'b1;
  endfunction

  task automatic stamp_trace(logic [dege_pkg::KIND_W-1:0] kind,
                             logic [dege_pkg::ID_W-1:0] id, logic link_up);
    stamp_t s;
    s = '{default: '0};
    if (kind != dege_pkg::KIND_BEGIN && id_live(id)) begin
      s.cause = dege_pkg::CAUSE_ENDED;
    end else if (!link_up) begin
      s.cause = dege_pkg::CAUSE_LINK;
    end else begin
      s.cause = dege_pkg::CAUSE_NONE;
      s.seq = next_seq;
      if (next_seq != dege_pkg::CNT_MAX) next_seq = next_seq + 1'b1;
      sent_total = sat_inc(sent_total);
      if (kind == dege_pkg::KIND_BEGIN) begin
        foreach (ended_ids[i])
          if (ended_ids[i] == id) ended_live[i] = 1'b0;
      end else if (kind == dege_pkg::KIND_END && !id_live(id)) begin
        // drop the oldest entry, live or spent, when the window is full
        if (ended_ids.size() == dege_pkg::WINDOW_DEPTH_DEF) begin
          ended_ids.delete(0);
          ended_live.delete(0);
          evict_count++;
        end
        ended_ids.push_back(id);
        ended_live.push_back(1'b1);
      end
    end
    s.accepted = (s.cause == dege_pkg::CAUSE_NONE);
    if (s.accepted) sent_count++;
    else refused_total = sat_inc(refused_total);
    if (s.cause == dege_pkg::CAUSE_ENDED) ended_count++;
    if (s.cause == dege_pkg::CAUSE_LINK) link_count++;
    s.sent_total = sent_total;
    s.refused_total = refused_total;
    expected_stamps.push_back(s);
  endtask

  task automatic check_field(string name, logic [CW-1:0] want, logic [CW-1:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch in %s: expected %0h, got %0h", name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    stamp_t want;
    if (!rst_n) begin
      expected_stamps.delete();
      ended_ids.delete();
      ended_live.delete();
      next_seq = CW'(1);
      sent_total = '0;
      refused_total = '0;
      fail_count = 0;
      pending = 0;
      sent_count = 0;
      ended_count = 0;
      link_count = 0;
      evict_count = 0;
    end else begin
      if (in_tvalid && in_tready)
        stamp_trace(in_tuser, in_tdata[31:0], in_tdata[32]);
      if (out_tvalid && out_tready) begin
        if (expected_stamps.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result transfer: %0h", out_tdata);
        end else begin
          want = expected_stamps[0];
          expected_stamps.delete(0);
          check_field("accepted", CW'(want.accepted), CW'(out_tdata[0]));
          check_field("refuse_cause", CW'(want.cause), CW'(out_tdata[2:1]));
          check_field("sequence_number", want.seq, out_tdata[50:3]);
          check_field("accepted_total", want.sent_total, out_tdata[98:51]);
          check_field("rejected_total", want.refused_total, out_tdata[146:99]);
        end
      end
      pending = expected_stamps.size();
    end
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Top of the dispatch end guard sequencer testbench: clock, reset, stimulus,
// result-side back-pressure and verdict. Depends on dege_pkg and dege_stamp_checker.
module tb_top;

  localparam logic [dege_pkg::KIND_W-1:0] KIND_OTHER = 2'd2;
  localparam logic [dege_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int RANDOM_ITEMS    = 2000;
  localparam int IDLE_LIMIT      = 3000;
  localparam int PRESSURE_AFTER  = 300;
  localparam int PRESSURE_CYCLES = 400;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [39:0]  in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [151:0] out_tdata;

  int fail_count, pending, sent_count, ended_count, link_count, evict_count;
  int items_sent = 0;
  int results_taken = 0;
  int idle_cycles = 0;
  int gap_max = 14;
  bit burst_out = 1'b0;
  bit pressure_done = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  dispatch_end_guard_sequencer dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  dege_stamp_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending(pending), .sent_count(sent_count),
    .ended_count(ended_count), .link_count(link_count), .evict_count(evict_count)
  );

  task automatic offer(logic [dege_pkg::KIND_W-1:0] kind,
                       logic [dege_pkg::ID_W-1:0] id, logic link_up);
    int gap;
    gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {7'd0, link_up, id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  initial begin : stimulus
    logic [dege_pkg::ID_W-1:0] pool[128];
    logic [dege_pkg::ID_W-1:0] id;
    logic [dege_pkg::KIND_W-1:0] kind;
    int pool_n, seg_len, w;
    bit sweep;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer(KIND_OTHER,          32'h0000_0000, 1'b1);
    offer(dege_pkg::KIND_END,   32'h0000_0000, 1'b0);
    offer(KIND_OTHER,          32'h0000_0000, 1'b1);
    offer(dege_pkg::KIND_END,   32'h0000_0000, 1'b1);
    offer(dege_pkg::KIND_END,   32'h0000_0000, 1'b1);
    offer(KIND_OTHER,          32'h0000_0000, 1'b1);
    offer(KIND_SPARE,          32'h0000_0000, 1'b0);
    offer(dege_pkg::KIND_BEGIN, 32'h0000_0000, 1'b0);
    offer(KIND_OTHER,          32'h0000_0000, 1'b1);
    offer(dege_pkg::KIND_BEGIN, 32'h0000_0000, 1'b1);
    offer(KIND_OTHER,          32'h0000_0000, 1'b1);
    offer(dege_pkg::KIND_END,   32'hFFFF_FFFF, 1'b1);
    offer(KIND_SPARE,          32'hFFFF_FFFF, 1'b1);
    offer(dege_pkg::KIND_END,   32'h0000_0000, 1'b1);
    offer(dege_pkg::KIND_BEGIN, 32'hFFFF_FFFF, 1'b1);
    offer(KIND_SPARE,          32'hFFFF_FFFF, 1'b1);
    offer(dege_pkg::KIND_END,   32'hFFFF_FFFF, 1'b0);
    offer(KIND_OTHER,          32'h0000_0000, 1'b0);
    offer(dege_pkg::KIND_BEGIN, 32'h0000_0000, 1'b1);
    offer(KIND_SPARE,          32'h5555_AAAA, 1'b0);

    while (items_sent < RANDOM_ITEMS + 20) begin
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
      sweep = 1'b0;
      case ($urandom_range(0, 2))
        0: pool_n = $urandom_range(2, 16);
        1: pool_n = $urandom_range(40, 120);
        default: begin
          pool_n = $urandom_range(65, 90);
          sweep = 1'b1;
        end
      endcase
      for (int j = 0; j < pool_n; j++) pool[j] = $urandom;
      if ($urandom_range(0, 3) == 0) pool[0] = '0;
      if ($urandom_range(0, 3) == 0) pool[1] = '1;
      // push the window past full, then revisit ids that have dropped out
      if (sweep)
        for (int j = 0; j < pool_n; j++) offer(dege_pkg::KIND_END, pool[j], 1'b1);
      seg_len = $urandom_range(40, 150);
      repeat (seg_len) begin
        w = $urandom_range(0, 99);
        kind = (w < 30) ? dege_pkg::KIND_BEGIN :
               (w < 65) ? dege_pkg::KIND_END :
               (w < 90) ? KIND_OTHER : KIND_SPARE;
        id = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, pool_n - 1)];
        offer(kind, id, $urandom_range(0, 7) != 0);
      end
    end
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("covered %0d events: %0d sent, %0d refused as ended, %0d refused on link",
             items_sent, sent_count, ended_count, link_count);
    $display("window evictions %0d, mismatches %0d", evict_count, fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : receiver
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = burst_out ? 0 : $urandom_range(0, 14);
      // hold off long enough for the block to fill and stall its input
      if (!pressure_done && results_taken >= PRESSURE_AFTER) begin
        stall = PRESSURE_CYCLES;
        pressure_done = 1'b1;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      results_taken++;
      if (results_taken % 50 == 0) burst_out = ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d cycles without a transfer", idle_cycles);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ----- filelist.f -----
rtl/dege_pkg.sv
rtl/dege_cell.sv
rtl/dege_window.sv
rtl/dispatch_end_guard_sequencer.sv
tb/dege_stamp_checker.sv
tb/tb_top.sv
